@@ src/assert_macros.svh @@
// assertion macros for the list engine control module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define PLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// types, sizes and codes shared by the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int ENTRY_W  = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_READ      = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  pos;   // insert / delete slot
    logic [CNT_W-1:0]  tail;  // last occupied slot, for rotation
    logic [VAL_W-1:0]  din;   // value to insert
  } cell_ctl_t;

endpackage

@@ src/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// one slot of the list chain: holds, shifts right, shifts left or rotates
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                       clk,
  input  ple_pkg::cell_ctl_t         ctl,
  input  logic [ple_pkg::IDX_W-1:0]  cell_idx,
  input  logic [ple_pkg::VAL_W-1:0]  left_q,
  input  logic [ple_pkg::VAL_W-1:0]  right_q,
  input  logic [ple_pkg::VAL_W-1:0]  head_q,
  output logic [ple_pkg::VAL_W-1:0]  q
);
  import ple_pkg::*;

  logic [CNT_W-1:0] my;
  logic [VAL_W-1:0] q_next;

  assign my = CNT_W'(cell_idx);

  always_comb begin
    q_next = q;
    case (ctl.op)
      CELL_INS: begin
        if (my == ctl.pos) begin
          q_next = ctl.din;
        end else if (my > ctl.pos) begin
          q_next = left_q;
        end
      end
      CELL_DEL: begin
        if (my >= ctl.pos) begin
          q_next = right_q;
        end
      end
      CELL_ROT: begin
        // head wraps to the tail so the list comes back whole
        if (my == ctl.tail) begin
          q_next = head_q;
        end else if (my < ctl.tail) begin
          q_next = right_q;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ src/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// request decode, entry count, read-out sequencing and result register
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [2:0]                   req_type,
  input  logic [ple_pkg::POS_W-1:0]    position,
  input  logic [ple_pkg::VAL_W-1:0]    value,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [1:0]                   status,
  output logic [ple_pkg::VAL_W-1:0]    read_value,
  output logic [ple_pkg::ENTRY_W-1:0]  entry_count,
  output logic                         last,
  output ple_pkg::cell_ctl_t           ctl,
  input  logic [ple_pkg::VAL_W-1:0]    head_q
);
  import ple_pkg::*;

  fsm_t             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic             accept, slot_free, load;
  logic             full, empty;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic [CNT_W-1:0] pos_m1;
  status_t          st_new;
  logic [VAL_W-1:0] val_new;
  logic [CNT_W-1:0] cnt_out;
  logic             last_new;

  // no item is taken while reset is held
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = !rst && (state == FSM_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign pos_ext   = CMP_W'(position);
  assign cnt_ext   = CMP_W'(count);
  assign pos_m1    = CNT_W'(pos_ext - CMP_W'(1));

  always_comb begin
    state_next  = state;
    count_next  = count;
    rd_cnt_next = rd_cnt;
    load        = 1'b0;
    st_new      = ST_OK;
    val_new     = '0;
    last_new    = 1'b1;
    ctl.op      = CELL_HOLD;
    ctl.pos     = '0;
    ctl.tail    = count - CNT_W'(1);
    ctl.din     = value;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (req_type)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
              if (full) begin
                st_new = ST_FULL;
              end else if (req_type == REQ_INS_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                st_new = ST_NOTFOUND;
              end else begin
                ctl.op     = CELL_INS;
                count_next = count + CNT_W'(1);
                if (req_type == REQ_INS_FRONT) begin
                  ctl.pos = '0;
                end else if (req_type == REQ_INS_BACK) begin
                  ctl.pos = count;
                end else begin
                  ctl.pos = pos_m1;
                end
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
              if (empty) begin
                st_new = ST_EMPTY;
              end else if (req_type == REQ_DEL_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext)) begin
                st_new = ST_NOTFOUND;
              end else begin
                ctl.op     = CELL_DEL;
                count_next = count - CNT_W'(1);
                if (req_type == REQ_DEL_FRONT) begin
                  ctl.pos = '0;
                end else if (req_type == REQ_DEL_BACK) begin
                  ctl.pos = count - CNT_W'(1);
                end else begin
                  ctl.pos = pos_m1;
                end
              end
            end
            REQ_READ: begin
              if (empty) begin
                st_new = ST_EMPTY;
              end else begin
                load        = 1'b0;
                rd_cnt_next = '0;
                state_next  = FSM_READ;
              end
            end
            default: st_new = ST_OK;
          endcase
        end
      end
      FSM_READ: begin
        if (slot_free) begin
          load        = 1'b1;
          val_new     = head_q;
          last_new    = (rd_cnt == count - CNT_W'(1));
          ctl.op      = CELL_ROT;
          rd_cnt_next = rd_cnt + CNT_W'(1);
          if (last_new) begin
            state_next = FSM_IDLE;
          end
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  assign cnt_out = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      count    <= '0;
      rd_cnt   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_cnt <= rd_cnt_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= st_new;
      read_value  <= val_new;
      entry_count <= ENTRY_W'(cnt_out);
      last        <= last_new;
    end
  end

`include "assert_macros.svh"

  `PLE_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `PLE_ASSERT(a_read_blocks, (state == FSM_READ) |-> !s_tready, "request taken during read-out")
  `PLE_ASSERT(a_mid_only_read, (m_tvalid && !last) |-> (state == FSM_READ), "non-final result outside read-out")
  `PLE_ASSERT(a_read_start, (accept && req_type == REQ_READ && !empty) |=> (state == FSM_READ), "read-out did not start")

endmodule

@@ src/positional_list_engine.sv @@
// result: an insert, delete or refused request loads the result register as the item is taken
// throughput: one request per cycle for inserts, deletes and reads of an empty list, while the result slot is free
// read-out gives one result per cycle per entry while the result slot is free, paced by the head cell rotation
// reset: synchronous active-high rst empties the list; cell contents are left as they are
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of unsigned 32-bit values kept in a chain of shifting cells
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  input  logic [39:0] s_tdata,   // [4:0] position, [36:5] value, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] status, [33:2] read_value, [38:34] entry_count
  output logic        m_tlast    // last result of the request
);
  import ple_pkg::*;

  cell_ctl_t          ctl;
  logic [VAL_W-1:0]   cell_q [CAPACITY];
  logic [1:0]         status;
  logic [VAL_W-1:0]   read_value;
  logic [ENTRY_W-1:0] entry_count;

  // control: decode, count and the registered result slot
  ple_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .req_type    (s_tuser),
    .position    (s_tdata[POS_W-1:0]),
    .value       (s_tdata[POS_W+VAL_W-1:POS_W]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count),
    .last        (m_tlast),
    .ctl         (ctl),
    .head_q      (cell_q[0])
  );

  // the chain: each cell sees both neighbors and the head for rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_q, right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_lastc
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    ple_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (IDX_W'(i)),
      .left_q   (left_q),
      .right_q  (right_q),
      .head_q   (cell_q[0]),
      .q        (cell_q[i])
    );
  end

  assign m_tdata = {1'b0, entry_count, read_value, status};

endmodule
